@@ hdl/esd_pkg.sv @@
package esd_pkg;

    // Saturation point of the decoded length and width of the length field
    localparam int LENGTH_MAX = 4096;
    localparam int LEN_W      = 13;

    // Result queue between the decoder and the result port
    localparam int FIFO_PTR_W = 2;
    localparam int FIFO_DEPTH = 1 << FIFO_PTR_W;
    localparam int FIFO_CNT_W = FIFO_PTR_W + 1;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } in_item_t;

    typedef struct packed {
        logic [7:0]       out_byte;
        logic             out_valid;
        logic             out_end;
        logic             out_error;
        logic [LEN_W-1:0] out_length;
    } out_item_t;

    // Results of one decode step: up to two, in order res0 then res1
    typedef struct packed {
        out_item_t  res0;
        out_item_t  res1;
        logic [1:0] num;
    } step_res_t;

endpackage

@@ hdl/esd_core.sv @@
module esd_core (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               advance,
    input  esd_pkg::in_item_t  item,
    output esd_pkg::step_res_t res
);
    import esd_pkg::*;

    localparam logic [1:0] MODE_NORMAL = 2'd0;
    localparam logic [1:0] MODE_ESC    = 2'd1;
    localparam logic [1:0] MODE_HEX    = 2'd2;
    localparam logic [1:0] MODE_OCT    = 2'd3;

    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_X         = 8'h78;
    localparam logic [7:0] ESC_CODE     = 8'h1B;

    logic [1:0]       mode_reg, mode_next;
    logic [1:0]       cnt_reg, cnt_next;
    logic [1:0]       lim_reg, lim_next;
    logic [7:0]       acc_reg, acc_next;
    logic             err_reg, err_next;
    logic [LEN_W-1:0] bcnt_reg, bcnt_next;

    // {digit ok, value}
    function automatic logic [4:0] hex_digit(input logic [7:0] ch);
        logic [4:0] r;
        r = 5'd0;
        if (ch >= 8'h30 && ch <= 8'h39) begin
            r = {1'b1, 4'(ch - 8'h30)};
        end else if (ch >= 8'h61 && ch <= 8'h66) begin
            r = {1'b1, 4'(ch - 8'h57)};
        end else if (ch >= 8'h41 && ch <= 8'h46) begin
            r = {1'b1, 4'(ch - 8'h37)};
        end
        return r;
    endfunction

    function automatic logic [7:0] esc_map(input logic [7:0] ch);
        logic [7:0] r;
        unique case (ch)
            8'h45, 8'h65: r = ESC_CODE;
            8'h6E:        r = 8'h0A;
            8'h72:        r = 8'h0D;
            8'h74:        r = 8'h09;
            8'h62:        r = 8'h08;
            8'h66:        r = 8'h0C;
            8'h61:        r = 8'h07;
            8'h76:        r = 8'h0B;
            default:      r = ch;
        endcase
        return r;
    endfunction

    logic [7:0]       c;
    logic [4:0]       hx;
    logic             oct_ok;
    logic [1:0]       mode, cnt, lim;
    logic [7:0]       acc;
    logic             err_mid, err_end, err_b, err_fin;
    logic             ea, eb, ec, ka, kb, kc;
    logic [7:0]       va, vb, vc, v0, v1;
    logic [1:0]       n;
    logic [LEN_W:0]   sum;
    logic [LEN_W-1:0] bsat;

    always_comb begin
        c       = item.in_byte;
        hx      = hex_digit(c);
        oct_ok  = (c >= 8'h30) && (c <= 8'h37);
        mode    = mode_reg;
        cnt     = cnt_reg;
        lim     = lim_reg;
        acc     = acc_reg;
        err_mid = 1'b0;
        err_end = 1'b0;
        ea = 1'b0; va = 8'd0;
        eb = 1'b0; vb = 8'd0;
        ec = 1'b0; vc = 8'd0;

        unique case (mode_reg)
            MODE_NORMAL: begin
                if (c == CH_BACKSLASH) begin
                    mode = MODE_ESC;
                end else begin
                    eb = 1'b1;
                    vb = c;
                end
            end
            MODE_ESC: begin
                mode = MODE_NORMAL;
                if (c == CH_X) begin
                    mode = MODE_HEX;
                    cnt  = 2'd0;
                    lim  = 2'd2;
                    acc  = 8'd0;
                end else if (oct_ok) begin
                    mode = MODE_OCT;
                    acc  = {5'd0, c[2:0]};
                    cnt  = 2'd1;
                    lim  = c[2] ? 2'd2 : 2'd3;
                end else begin
                    ea = 1'b1;
                    va = esc_map(c);
                end
            end
            MODE_HEX: begin
                if (hx[4]) begin
                    acc = {acc_reg[3:0], hx[3:0]};
                    cnt = cnt_reg + 2'd1;
                    if (cnt >= lim_reg) begin
                        ea   = 1'b1;
                        va   = acc;
                        mode = MODE_NORMAL;
                    end
                end else begin
                    if (cnt_reg == 2'd0) begin
                        err_mid = 1'b1;
                    end else begin
                        ea = 1'b1;
                        va = acc_reg;
                    end
                    mode = MODE_NORMAL;
                    if (c == CH_BACKSLASH) begin
                        mode = MODE_ESC;
                    end else begin
                        eb = 1'b1;
                        vb = c;
                    end
                end
            end
            MODE_OCT: begin
                if (oct_ok) begin
                    acc = {acc_reg[4:0], c[2:0]};
                    cnt = cnt_reg + 2'd1;
                    if (cnt >= lim_reg) begin
                        ea   = 1'b1;
                        va   = acc;
                        mode = MODE_NORMAL;
                    end
                end else begin
                    ea   = 1'b1;
                    va   = acc_reg;
                    mode = MODE_NORMAL;
                    if (c == CH_BACKSLASH) begin
                        mode = MODE_ESC;
                    end else begin
                        eb = 1'b1;
                        vb = c;
                    end
                end
            end
            default: ;
        endcase

        // Flush whatever escape is still open at the end of the string
        if (item.in_last) begin
            unique case (mode)
                MODE_ESC: err_end = 1'b1;
                MODE_HEX: begin
                    if (cnt == 2'd0) begin
                        err_end = 1'b1;
                    end else begin
                        ec = 1'b1;
                        vc = acc;
                    end
                end
                MODE_OCT: begin
                    ec = 1'b1;
                    vc = acc;
                end
                default: ;
            endcase
        end

        // Drop output once an error is latched
        err_b   = err_reg | err_mid;
        err_fin = err_b | err_end;
        ka = ea & ~err_reg;
        kb = eb & ~err_b;
        kc = ec & ~err_b;
        n  = {1'b0, ka} + {1'b0, kb} + {1'b0, kc};

        sum  = {1'b0, bcnt_reg} + {{(LEN_W-1){1'b0}}, n};
        bsat = (sum > (LEN_W+1)'(LENGTH_MAX)) ? LEN_W'(LENGTH_MAX) : sum[LEN_W-1:0];

        v0 = ka ? va : (kb ? vb : vc);
        v1 = (ka && kb) ? vb : vc;

        res.res0 = '{out_byte: v0, out_valid: 1'b1, out_end: 1'b0, out_error: 1'b0,
                     out_length: '0};
        res.res1 = '{out_byte: v1, out_valid: 1'b1, out_end: 1'b0, out_error: 1'b0,
                     out_length: '0};
        res.num  = n;

        if (item.in_last) begin
            if (n == 2'd2) begin
                res.res1.out_end    = 1'b1;
                res.res1.out_error  = err_fin;
                res.res1.out_length = err_fin ? '0 : bsat;
            end else begin
                if (n == 2'd0) begin
                    res.res0.out_byte  = 8'd0;
                    res.res0.out_valid = 1'b0;
                end
                res.res0.out_end    = 1'b1;
                res.res0.out_error  = err_fin;
                res.res0.out_length = err_fin ? '0 : bsat;
                res.num             = 2'd1;
            end
            mode_next = MODE_NORMAL;
            cnt_next  = 2'd0;
            lim_next  = 2'd0;
            acc_next  = 8'd0;
            err_next  = 1'b0;
            bcnt_next = '0;
        end else begin
            mode_next = mode;
            cnt_next  = cnt;
            lim_next  = lim;
            acc_next  = acc;
            err_next  = err_b;
            bcnt_next = bsat;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_NORMAL;
            cnt_reg  <= 2'd0;
            lim_reg  <= 2'd0;
            acc_reg  <= 8'd0;
            err_reg  <= 1'b0;
            bcnt_reg <= '0;
        end else if (advance) begin
            mode_reg <= mode_next;
            cnt_reg  <= cnt_next;
            lim_reg  <= lim_next;
            acc_reg  <= acc_next;
            err_reg  <= err_next;
            bcnt_reg <= bcnt_next;
        end
    end

endmodule

@@ hdl/esd_fifo.sv @@
module esd_fifo (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               wr_en,
    input  esd_pkg::step_res_t wr_res,
    output logic               room,
    output logic               m_valid,
    input  logic               m_ready,
    output esd_pkg::out_item_t m_data
);
    import esd_pkg::*;

    out_item_t             mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [FIFO_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [FIFO_CNT_W-1:0] count_reg, count_next;
    logic [1:0]            wr_num;
    logic                  pop;

    assign wr_num  = wr_en ? wr_res.num : 2'd0;
    assign m_valid = (count_reg != '0);
    assign m_data  = mem[rd_ptr_reg];
    assign pop     = m_valid & m_ready;
    // Two free slots cover the worst step
    assign room    = (count_reg <= FIFO_CNT_W'(FIFO_DEPTH - 2));

    assign wr_ptr_next = wr_ptr_reg + FIFO_PTR_W'(wr_num);
    assign rd_ptr_next = rd_ptr_reg + FIFO_PTR_W'(pop);
    assign count_next  = count_reg + FIFO_CNT_W'(wr_num) - FIFO_CNT_W'(pop);

    always_ff @(posedge aclk) begin
        if (wr_num != 2'd0) begin
            mem[wr_ptr_reg] <= wr_res.res0;
        end
        if (wr_num == 2'd2) begin
            mem[wr_ptr_reg + FIFO_PTR_W'(1)] <= wr_res.res1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= FIFO_CNT_W'(FIFO_DEPTH))
        else $error("result queue count beyond depth");

    a_pair_fits: assert property (@(posedge aclk) disable iff (!aresetn)
        (wr_num == 2'd2) |-> (count_reg <= FIFO_CNT_W'(FIFO_DEPTH - 2)))
        else $error("two results written without room");

    a_write_shows: assert property (@(posedge aclk) disable iff (!aresetn)
        (wr_num != 2'd0) |=> m_valid)
        else $error("written result not presented");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> (count_reg == '0))
        else $error("queue not empty after reset");

endmodule

@@ hdl/escape_sequence_decoder.sv @@
// Streaming decoder for C-style backslash escapes. Send one character per
// transfer on s_data (in_byte, with in_last on the final character); decoded
// bytes come out on m_data, and the final result of each string carries
// out_end together with the error flag and the decoded length, saturating at
// 4096. That final result is either the string's last decoded byte or, when
// the last character decodes to nothing, an extra result with out_valid low.
// An input transfer is taken every cycle as long as the result side keeps
// pace: a character yields zero, one or two results, and the result port
// moves one per cycle while m_ready is high, so the sustained rate is one
// character per cycle for strings whose characters give one result each,
// and is otherwise set by the result count at the port. A character waits
// in the input register until the queue has room for two results, then the
// decode step writes its results into a four-entry result queue whose head
// drives m_data and m_valid.
// Errors (\x without digits, a trailing backslash) latch for the rest of the
// string and drop its remaining bytes; all state clears after each string.
module escape_sequence_decoder (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  esd_pkg::in_item_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output esd_pkg::out_item_t m_data
);
    import esd_pkg::*;

    in_item_t  in_reg;
    logic      in_valid_reg;
    logic      room;
    logic      advance;
    step_res_t step_res;

    // Advance the held character into the decoder once the queue can take
    // the worst case of two results.
    assign advance = in_valid_reg & room;
    assign s_ready = ~in_valid_reg | advance;

    // Hold the accepted character; payload needs no reset.
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_reg <= s_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    // Decode step: escape parser state and per-character results.
    esd_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (advance),
        .item    (in_reg),
        .res     (step_res)
    );

    // Result queue: up to two writes, one read per cycle.
    esd_fifo u_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (advance),
        .wr_res  (step_res),
        .room    (room),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule
